FILE: rtl/scee_pkg.sv
package scee_pkg;

   // radius fields are fixed Q14.8 codes
   localparam int RADIUS_WIDTH = 22;

   // both radii summed, one carry bit
   localparam int RSUM_WIDTH = RADIUS_WIDTH + 1;

endpackage

FILE: rtl/segment_circle_entry_exit_top.sv
// Segment / circle entry-exit unit.
// Input: pulse start with the segment start, motion vector, circle center and
// the two radii on the req_ ports; a word is taken at each clock edge where
// start is high and busy is low. Busy is only high during reset and the cycle
// after it, so one word can be taken every cycle.
// Output: rsp_valid is high for one cycle with hit, degenerate and the entry
// and exit points on the rsp_ ports. Every accepted word gives exactly one
// result word, in order. There is no backpressure on the result side.
// The square root of the discriminant is computed one root bit per stage and
// the point division one quotient bit per stage; multipliers register their
// partial products and then their sum.
// Throughput is one word per cycle.
// Reset clears the valid pipeline; words in flight are dropped.
module segment_circle_entry_exit_top #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_WIDTH-1:0]       req_start_x,
   input  logic signed [COORD_WIDTH-1:0]       req_start_y,
   input  logic signed [COORD_WIDTH-1:0]       req_move_x,
   input  logic signed [COORD_WIDTH-1:0]       req_move_y,
   input  logic signed [COORD_WIDTH-1:0]       req_center_x,
   input  logic signed [COORD_WIDTH-1:0]       req_center_y,
   input  logic [scee_pkg::RADIUS_WIDTH-1:0]   req_radius_a,
   input  logic [scee_pkg::RADIUS_WIDTH-1:0]   req_radius_b,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic                                rsp_degenerate,
   output logic signed [COORD_WIDTH-1:0]       rsp_enter_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_enter_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_exit_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_exit_y
);

   localparam int W   = COORD_WIDTH;
   localparam int RSW = scee_pkg::RSUM_WIDTH;
   localparam int R2W = 2 * RSW;
   localparam int AW  = 2 * W;
   localparam int PW  = W + 1;
   localparam int XW  = 2 * W + 1;
   localparam int BW  = 2 * W + 2;
   localparam int CMW = 2 * W + 1;
   localparam int LW  = AW + R2W;
   localparam int RHW = 2 * CMW;
   localparam int CW  = (LW > RHW) ? LW : RHW;
   localparam int SQ  = (LW + 1) / 2;
   localparam int EW  = ((BW > SQ + 1) ? BW : SQ + 1) + 1;
   localparam int NPW = 3 * W;
   localparam int OW  = W + 2;
   localparam int LAT = SQ + W + 14;

   localparam logic signed [OW-1:0] MAXV = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [OW-1:0] MINV = {3'b111, {(W-1){1'b0}}};

   logic            busy_ff;
   logic            accept;
   logic [LAT-2:0]  vld_ff;

   // stage 1
   logic signed [PW-1:0]  px1_ff, py1_ff;
   logic [RSW-1:0]        rsum1_ff;
   logic signed [W-1:0]   sx1_ff, sy1_ff, mx1_ff, my1_ff;
   logic                  degen1_ff;
   // stage 2
   logic [W-1:0]          mxm1, mym1;
   logic [AW-1:0]         mxx2_ff, myy2_ff;
   logic signed [XW-1:0]  pxmx2_ff, pymy2_ff, pxmy2_ff, pymx2_ff;
   logic [R2W-1:0]        rsq2_ff;
   // stage 3
   logic signed [BW-1:0]  cr2;
   logic [AW-1:0]         a3_ff;
   logic signed [BW-1:0]  b3_ff;
   logic [CMW-1:0]        cm3_ff;
   logic [R2W-1:0]        rsq3_ff;
   // discriminant
   logic [LW-1:0]         lhs5;
   logic [RHW-1:0]        rhs5;
   logic [CW-1:0]         lhs_c, rhs_c;
   logic                  miss4_ff;
   logic [LW-1:0]         sig4_ff;
   logic [SQ-1:0]         root7;
   // roots
   logic signed [BW-1:0]  b7d;
   logic signed [EW-1:0]  e1_ff, e2_ff;
   logic [AW-1:0]         a5d, a8d;
   logic signed [EW-1:0]  a_e;
   logic                  miss8d, degen8d;
   logic signed [W-1:0]   sx8d, sy8d, mx8d, my8d;
   logic                  hit6_ff, degen6_ff, sgnx6_ff, sgny6_ff;
   logic signed [W-1:0]   sx6_ff, sy6_ff;
   logic [W-1:0]          mxm6_ff, mym6_ff;
   logic [AW-1:0]         n1_ff, n2_ff;
   // points
   logic [NPW-1:0]        pe_x, pe_y, px_x, px_y;
   logic [W:0]            qe_x, qe_y, qx_x, qx_y;
   logic                  hit_d, degen_d, sgnx_d, sgny_d;
   logic signed [W-1:0]   sx_d, sy_d;

   logic                  rsp_valid_ff, rsp_hit_ff, rsp_degenerate_ff;
   logic signed [W-1:0]   rsp_enter_x_ff, rsp_enter_y_ff, rsp_exit_x_ff, rsp_exit_y_ff;

   function automatic logic [W-1:0] place(input logic signed [W-1:0] st,
                                          input logic neg, input logic [W:0] q);
      logic signed [OW-1:0] off;
      logic signed [OW-1:0] sum;
      off = neg ? -signed'(OW'(q)) : signed'(OW'(q));
      sum = OW'(st) + off;
      if (sum > MAXV) begin
         return MAXV[W-1:0];
      end else if (sum < MINV) begin
         return MINV[W-1:0];
      end
      return sum[W-1:0];
   endfunction

   assign busy   = busy_ff || reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         vld_ff       <= {vld_ff[LAT-3:0], accept};
         rsp_valid_ff <= vld_ff[LAT-2];
      end
   end

   // stage 1: circle-local start, radius sum
   always_ff @(posedge clock) begin
      px1_ff    <= PW'(req_start_x) - PW'(req_center_x);
      py1_ff    <= PW'(req_start_y) - PW'(req_center_y);
      rsum1_ff  <= RSW'(req_radius_a) + RSW'(req_radius_b);
      sx1_ff    <= req_start_x;
      sy1_ff    <= req_start_y;
      mx1_ff    <= req_move_x;
      my1_ff    <= req_move_y;
      degen1_ff <= (req_move_x == '0) && (req_move_y == '0);
   end

   // stage 2: products
   assign mxm1 = mx1_ff[W-1] ? W'(-mx1_ff) : W'(mx1_ff);
   assign mym1 = my1_ff[W-1] ? W'(-my1_ff) : W'(my1_ff);

   always_ff @(posedge clock) begin
      mxx2_ff  <= AW'(mxm1) * AW'(mxm1);
      myy2_ff  <= AW'(mym1) * AW'(mym1);
      pxmx2_ff <= XW'(px1_ff) * XW'(mx1_ff);
      pymy2_ff <= XW'(py1_ff) * XW'(my1_ff);
      pxmy2_ff <= XW'(px1_ff) * XW'(my1_ff);
      pymx2_ff <= XW'(py1_ff) * XW'(mx1_ff);
      rsq2_ff  <= R2W'(rsum1_ff) * R2W'(rsum1_ff);
   end

   // stage 3: a = d.d, b = p.d, |p x d|
   assign cr2 = BW'(pxmy2_ff) - BW'(pymx2_ff);

   always_ff @(posedge clock) begin
      a3_ff   <= mxx2_ff + myy2_ff;
      b3_ff   <= BW'(pxmx2_ff) + BW'(pymy2_ff);
      cm3_ff  <= cr2[BW-1] ? CMW'(-cr2) : CMW'(cr2);
      rsq3_ff <= rsq2_ff;
   end

   scee_mul #(.A_WIDTH(AW), .B_WIDTH(R2W), .CHUNK(W)) u_mul_lhs (
      .clock(clock), .a(a3_ff), .b(rsq3_ff), .p(lhs5)
   );

   scee_mul #(.A_WIDTH(CMW), .B_WIDTH(CMW), .CHUNK(W)) u_mul_rhs (
      .clock(clock), .a(cm3_ff), .b(cm3_ff), .p(rhs5)
   );

   // discriminant a*R^2 - cross^2
   assign lhs_c = CW'(lhs5);
   assign rhs_c = CW'(rhs5);

   always_ff @(posedge clock) begin
      miss4_ff <= lhs_c < rhs_c;
      sig4_ff  <= LW'(lhs_c - rhs_c);
   end

   scee_sqrt #(.IN_WIDTH(LW)) u_sqrt (
      .clock(clock), .radicand(sig4_ff), .root(root7)
   );

   scee_delay #(.WIDTH(BW), .DEPTH(SQ + 4)) u_dly_b (
      .clock(clock), .din(b3_ff), .dout(b7d)
   );

   scee_delay #(.WIDTH(AW), .DEPTH(SQ + 5)) u_dly_a (
      .clock(clock), .din(a3_ff), .dout(a5d)
   );

   scee_delay #(.WIDTH(AW), .DEPTH(3)) u_dly_a2 (
      .clock(clock), .din(a5d), .dout(a8d)
   );

   scee_delay #(.WIDTH(1), .DEPTH(SQ + 2)) u_dly_miss (
      .clock(clock), .din(miss4_ff), .dout(miss8d)
   );

   scee_delay #(.WIDTH(4*W+1), .DEPTH(SQ + 7)) u_dly_xy (
      .clock(clock),
      .din({degen1_ff, sx1_ff, sy1_ff, mx1_ff, my1_ff}),
      .dout({degen8d, sx8d, sy8d, mx8d, my8d})
   );

   // entry/exit numerators -b -/+ s
   always_ff @(posedge clock) begin
      e1_ff <= -EW'(b7d) - EW'(root7);
      e2_ff <= EW'(root7) - EW'(b7d);
   end

   // hit test and clamp to [0, a]
   assign a_e = EW'(a5d);

   always_ff @(posedge clock) begin
      hit6_ff   <= !miss8d && !degen8d && !(e1_ff > a_e) && !(e2_ff < 0);
      degen6_ff <= degen8d;
      n1_ff     <= e1_ff[EW-1] ? '0 : AW'(e1_ff);
      n2_ff     <= (e2_ff > a_e) ? a5d : AW'(e2_ff);
      mxm6_ff   <= mx8d[W-1] ? W'(-mx8d) : W'(mx8d);
      mym6_ff   <= my8d[W-1] ? W'(-my8d) : W'(my8d);
      sgnx6_ff  <= mx8d[W-1];
      sgny6_ff  <= my8d[W-1];
      sx6_ff    <= sx8d;
      sy6_ff    <= sy8d;
   end

   scee_mul #(.A_WIDTH(W), .B_WIDTH(AW), .CHUNK(W)) u_mul_ex (
      .clock(clock), .a(mxm6_ff), .b(n1_ff), .p(pe_x)
   );
   scee_mul #(.A_WIDTH(W), .B_WIDTH(AW), .CHUNK(W)) u_mul_ey (
      .clock(clock), .a(mym6_ff), .b(n1_ff), .p(pe_y)
   );
   scee_mul #(.A_WIDTH(W), .B_WIDTH(AW), .CHUNK(W)) u_mul_xx (
      .clock(clock), .a(mxm6_ff), .b(n2_ff), .p(px_x)
   );
   scee_mul #(.A_WIDTH(W), .B_WIDTH(AW), .CHUNK(W)) u_mul_xy (
      .clock(clock), .a(mym6_ff), .b(n2_ff), .p(px_y)
   );

   scee_div #(.NUM_WIDTH(NPW), .DEN_WIDTH(AW), .QUO_WIDTH(W)) u_div_ex (
      .clock(clock), .num(pe_x), .den(a8d), .quo(qe_x)
   );
   scee_div #(.NUM_WIDTH(NPW), .DEN_WIDTH(AW), .QUO_WIDTH(W)) u_div_ey (
      .clock(clock), .num(pe_y), .den(a8d), .quo(qe_y)
   );
   scee_div #(.NUM_WIDTH(NPW), .DEN_WIDTH(AW), .QUO_WIDTH(W)) u_div_xx (
      .clock(clock), .num(px_x), .den(a8d), .quo(qx_x)
   );
   scee_div #(.NUM_WIDTH(NPW), .DEN_WIDTH(AW), .QUO_WIDTH(W)) u_div_xy (
      .clock(clock), .num(px_y), .den(a8d), .quo(qx_y)
   );

   scee_delay #(.WIDTH(2*W+4), .DEPTH(W + 4)) u_dly_out (
      .clock(clock),
      .din({hit6_ff, degen6_ff, sgnx6_ff, sgny6_ff, sx6_ff, sy6_ff}),
      .dout({hit_d, degen_d, sgnx_d, sgny_d, sx_d, sy_d})
   );

   // result word; points zero unless hit
   always_ff @(posedge clock) begin
      rsp_hit_ff        <= hit_d;
      rsp_degenerate_ff <= degen_d;
      rsp_enter_x_ff    <= hit_d ? place(sx_d, sgnx_d, qe_x) : '0;
      rsp_enter_y_ff    <= hit_d ? place(sy_d, sgny_d, qe_y) : '0;
      rsp_exit_x_ff     <= hit_d ? place(sx_d, sgnx_d, qx_x) : '0;
      rsp_exit_y_ff     <= hit_d ? place(sy_d, sgny_d, qx_y) : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_degenerate = rsp_degenerate_ff;
   assign rsp_enter_x    = rsp_enter_x_ff;
   assign rsp_enter_y    = rsp_enter_y_ff;
   assign rsp_exit_x     = rsp_exit_x_ff;
   assign rsp_exit_y     = rsp_exit_y_ff;

`ifndef SYNTHESIS
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LAT) rsp_valid)
      else $error("result word missing at fixed latency");

   a_degen_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_degenerate))
      else $error("degenerate motion reported as hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_enter_x == '0 && rsp_enter_y == '0 &&
                                   rsp_exit_x == '0 && rsp_exit_y == '0))
      else $error("nonzero points on a miss");
`endif

endmodule

FILE: rtl/scee_delay.sv
module scee_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
   end

   for (genvar k = 1; k < DEPTH; k++) begin : g_tap
      always_ff @(posedge clock) begin
         tap_ff[k] <= tap_ff[k-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

FILE: rtl/scee_mul.sv
module scee_mul #(
   parameter int A_WIDTH = 48,
   parameter int B_WIDTH = 46,
   parameter int CHUNK   = 24
) (
   input  logic                       clock,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic [A_WIDTH+B_WIDTH-1:0] p
);

   localparam int NA = (A_WIDTH + CHUNK - 1) / CHUNK;
   localparam int NB = (B_WIDTH + CHUNK - 1) / CHUNK;
   localparam int PW = A_WIDTH + B_WIDTH;

   logic [NA*CHUNK-1:0] a_pad;
   logic [NB*CHUNK-1:0] b_pad;
   logic [2*CHUNK-1:0]  pp_ff [0:NA*NB-1];
   logic [PW-1:0]       p_in;
   logic [PW-1:0]       p_ff;

   assign a_pad = (NA*CHUNK)'(a);
   assign b_pad = (NB*CHUNK)'(b);

   // partial products, one chunk pair each
   for (genvar i = 0; i < NA; i++) begin : g_row
      for (genvar j = 0; j < NB; j++) begin : g_col
         always_ff @(posedge clock) begin
            pp_ff[i*NB+j] <= (2*CHUNK)'(a_pad[i*CHUNK +: CHUNK])
                             * (2*CHUNK)'(b_pad[j*CHUNK +: CHUNK]);
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            p_in = p_in + (PW'(pp_ff[i*NB+j]) << ((i + j) * CHUNK));
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

FILE: rtl/scee_sqrt.sv
module scee_sqrt #(
   parameter int IN_WIDTH = 94
) (
   input  logic                        clock,
   input  logic [IN_WIDTH-1:0]         radicand,
   output logic [(IN_WIDTH+1)/2-1:0]   root
);

   localparam int RT  = (IN_WIDTH + 1) / 2;
   localparam int XW  = 2 * RT;
   localparam int RMW = RT + 2;

   logic [XW-1:0]  x_ff    [0:RT-1];
   logic [RMW-1:0] rem_ff  [0:RT-1];
   logic [RT-1:0]  root_ff [0:RT];

   always_ff @(posedge clock) begin
      x_ff[0]    <= XW'(radicand);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   // one root bit per stage, two radicand bits consumed
   for (genvar k = 0; k < RT; k++) begin : g_step
      logic [RMW-1:0] shifted;
      logic [RMW-1:0] trial;
      logic           take;

      assign shifted = {rem_ff[k][RMW-3:0], x_ff[k][XW-1 -: 2]};
      assign trial   = {root_ff[k], 2'b01};
      assign take    = shifted >= trial;

      always_ff @(posedge clock) begin
         root_ff[k+1] <= {root_ff[k][RT-2:0], take};
      end

      if (k < RT - 1) begin : g_carry
         always_ff @(posedge clock) begin
            x_ff[k+1]   <= x_ff[k] << 2;
            rem_ff[k+1] <= take ? shifted - trial : shifted;
         end
      end
   end

   assign root = root_ff[RT];

endmodule

FILE: rtl/scee_div.sv
module scee_div #(
   parameter int NUM_WIDTH = 72,
   parameter int DEN_WIDTH = 48,
   parameter int QUO_WIDTH = 24
) (
   input  logic                 clock,
   input  logic [NUM_WIDTH-1:0] num,
   input  logic [DEN_WIDTH-1:0] den,
   output logic [QUO_WIDTH:0]   quo
);

   localparam int QW = QUO_WIDTH;

   logic [NUM_WIDTH-1:0] num_ff [0:QW];
   logic [DEN_WIDTH-1:0] den_ff [0:QW];
   logic [QW-1:0]        q_ff   [0:QW];
   logic [DEN_WIDTH-1:0] rem;
   logic                 round_up;
   logic [QW:0]          quo_ff;

   always_ff @(posedge clock) begin
      num_ff[0] <= num;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
   end

   // restoring division, quotient MSB first
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [NUM_WIDTH-1:0] shifted;
      logic                 take;

      assign shifted = NUM_WIDTH'(den_ff[k]) << (QW - 1 - k);
      assign take    = num_ff[k] >= shifted;

      always_ff @(posedge clock) begin
         num_ff[k+1] <= take ? num_ff[k] - shifted : num_ff[k];
         den_ff[k+1] <= den_ff[k];
         q_ff[k+1]   <= {q_ff[k][QW-2:0], take};
      end
   end

   // round half away from zero on the magnitude
   assign rem      = num_ff[QW][DEN_WIDTH-1:0];
   assign round_up = {rem, 1'b0} >= {1'b0, den_ff[QW]};

   always_ff @(posedge clock) begin
      quo_ff <= {1'b0, q_ff[QW]} + (QW+1)'(round_up);
   end

   assign quo = quo_ff;

endmodule
